[src/wlrol_pkg.sv]
// Shared constants, command/status types and helpers for the record ring lookup block.
package wlrol_pkg;

  localparam int RING_ENTRIES = 16;
  localparam int LENGTH_BITS  = 16;

  localparam int SLOT_W   = $clog2(RING_ENTRIES);
  localparam int HANDLE_W = 32;
  localparam int LEN_IN_W = 16;
  localparam int OFF_W    = 20;
  localparam int BOFF_W   = 16;
  localparam int SLOT_OUT_W = 4;

  // Sum of all stored lengths fits here.
  localparam int BASE_W = LENGTH_BITS + $clog2(RING_ENTRIES + 1);
  localparam int CMP_W  = (BASE_W > OFF_W) ? BASE_W : OFF_W;

  localparam int IN_FIELDS_W  = HANDLE_W + LEN_IN_W + OFF_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_OUT_W + HANDLE_W + BOFF_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  typedef struct packed {
    logic load;
    logic add;
    logic walk;
    logic out_load;
  } wlrol_cmd_t;

  typedef struct packed {
    logic find_kind;
    logic walk_done;
    logic out_busy;
  } wlrol_sts_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(RING_ENTRIES - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

[src/wlrol_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
module wlrol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/wlrol_ctrl.sv]
// Controller state machine: sequences add, offset walk and result load.
module wlrol_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  wlrol_pkg::wlrol_sts_t sts,
  output wlrol_pkg::wlrol_cmd_t cmd
);
  import wlrol_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_xfer;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.load  = 1'b1;
          state_nxt = (sts.find_kind == KIND_FIND) ? ST_WALK : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_FILL;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/wlrol_dp.sv]
// Datapath: ring pointers, lengths, valid marks, handle store, walk adder and result register.
module wlrol_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wlrol_pkg::wlrol_cmd_t            cmd,
  output wlrol_pkg::wlrol_sts_t            sts,
  input  logic [wlrol_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wlrol_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tuser
);
  import wlrol_pkg::*;

  logic [HANDLE_W-1:0]    in_handle;
  logic [LEN_IN_W-1:0]    in_len;
  logic [OFF_W-1:0]       in_off;
  logic [LENGTH_BITS+LEN_IN_W-1:0] in_len_ext;

  logic [HANDLE_W-1:0]    handle_r;
  logic [LENGTH_BITS-1:0] len_in_r;
  logic [OFF_W-1:0]       off_r;

  logic [SLOT_W-1:0]      wr_slot_r;
  logic [SLOT_W-1:0]      rd_slot_r;
  logic                   full_r;
  logic [RING_ENTRIES-1:0] valid_r;
  logic [LENGTH_BITS-1:0] len_r [RING_ENTRIES];

  logic [SLOT_W-1:0]      idx_r;
  logic [SLOT_W-1:0]      cnt_r;
  logic [BASE_W-1:0]      base_r;

  logic                   res_hit_r;
  logic [SLOT_W-1:0]      res_slot_r;
  logic [LENGTH_BITS-1:0] res_boff_r;
  logic                   res_ram_r;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [SLOT_OUT_W-1:0]  out_slot_r;
  logic [HANDLE_W-1:0]    out_handle_r;
  logic [BOFF_W-1:0]      out_boff_r;

  logic [CMP_W-1:0]       diff;
  logic [LENGTH_BITS-1:0] cur_len;
  logic                   step_hit;
  logic [SLOT_W-1:0]      rd_slot_adv;
  logic [SLOT_W-1:0]      wr_slot_adv;

  logic                   ram_re;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [HANDLE_W-1:0]    ram_rdata;

  logic [SLOT_W+SLOT_OUT_W-1:0]  slot_ext;
  logic [LENGTH_BITS+BOFF_W-1:0] boff_ext;

  assign in_handle  = in_tdata[HANDLE_W-1:0];
  assign in_len     = in_tdata[HANDLE_W+LEN_IN_W-1:HANDLE_W];
  assign in_off     = in_tdata[IN_FIELDS_W-1:HANDLE_W+LEN_IN_W];
  assign in_len_ext = {{LENGTH_BITS{1'b0}}, in_len};

  // Walk step: offset never drops below base, so one subtract and compare.
  assign cur_len  = len_r[idx_r];
  assign diff     = CMP_W'(off_r) - CMP_W'(base_r);
  assign step_hit = valid_r[idx_r] && (diff < CMP_W'(cur_len));

  assign sts.find_kind = in_tuser;
  assign sts.walk_done = !valid_r[idx_r] || step_hit || (cnt_r == SLOT_W'(RING_ENTRIES - 1));
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign rd_slot_adv = full_r ? next_slot(rd_slot_r) : rd_slot_r;
  assign wr_slot_adv = next_slot(wr_slot_r);

  assign ram_re    = (cmd.add && full_r) || (cmd.walk && step_hit);
  assign ram_raddr = cmd.add ? rd_slot_r : idx_r;

  wlrol_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (RING_ENTRIES)
  ) u_handle_ram (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (wr_slot_r),
    .wdata (handle_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      full_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add) begin
        // when full the write slot is the evicted slot, so its mark stays set
        valid_r[wr_slot_r] <= 1'b1;
        rd_slot_r <= rd_slot_adv;
        wr_slot_r <= wr_slot_adv;
        full_r    <= (wr_slot_adv == rd_slot_adv);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_r};
  assign boff_ext = {{BOFF_W{1'b0}}, res_boff_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      handle_r   <= in_handle;
      len_in_r   <= in_len_ext[LENGTH_BITS-1:0];
      off_r      <= in_off;
      idx_r      <= rd_slot_r;
      cnt_r      <= '0;
      base_r     <= '0;
      res_hit_r  <= 1'b0;
      res_slot_r <= '0;
      res_boff_r <= '0;
      res_ram_r  <= 1'b0;
    end
    if (cmd.add) begin
      len_r[wr_slot_r] <= len_in_r;
      res_hit_r  <= full_r;
      res_slot_r <= wr_slot_r;
      res_ram_r  <= full_r;
    end
    if (cmd.walk) begin
      idx_r  <= next_slot(idx_r);
      cnt_r  <= cnt_r + 1'b1;
      base_r <= base_r + BASE_W'(cur_len);
      if (step_hit) begin
        res_hit_r  <= 1'b1;
        res_slot_r <= idx_r;
        res_boff_r <= diff[LENGTH_BITS-1:0];
        res_ram_r  <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_hit_r    <= res_hit_r;
      out_slot_r   <= slot_ext[SLOT_OUT_W-1:0];
      out_handle_r <= res_ram_r ? ram_rdata : '0;
      out_boff_r   <= boff_ext[BOFF_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_boff_r, out_handle_r, out_slot_r};

endmodule

[src/write_log_ring_offset_lookup.sv]
// Sequence: the input transfer loads the input registers; an add then runs the ADD state,
// a find the WALK state over k records (1 <= k <= RING_ENTRIES); both end in FILL, which
// loads the output register. One item at a time; the walk adds one length a cycle.
// A finished result waits in the output register while the next item is taken.
// Reset: synchronous, active low; ring empty, pointers zero, output idle.
// Handle store is not cleared; only records marked valid are ever read.
module write_log_ring_offset_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wlrol_pkg::IN_DATA_W-1:0]  in_tdata,   // entry_handle, entry_length, stream_pos
  input  logic                             in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wlrol_pkg::OUT_DATA_W-1:0] out_tdata,  // slot, out_handle, byte_offset
  output logic                             out_tuser   // hit
);
  import wlrol_pkg::*;

  wlrol_cmd_t cmd;
  wlrol_sts_t sts;

  wlrol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wlrol_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[src/wlrol_checker.sv]
// Port-level checker for the record ring lookup block, bound to the top level.
module wlrol_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wlrol_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[51:4] == 48'h0)
    else $error("result without hit carries handle or offset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind write_log_ring_offset_lookup wlrol_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
